@@ sv/hrcs_pkg.sv @@
// Types, register indexes and fixed-point constants for the hue range color splash.
// Shared by the channel interfaces, the top level and the checker.
package hrcs_pkg;

  localparam int unsigned TAB_DEPTH = 256;
  localparam int unsigned HUE_SPAN  = 180;
  localparam int unsigned HALF_TURN = 360;

  localparam int unsigned SAT_NUM = 255 * 4096;
  localparam int unsigned HUE_NUM = 180 * 4096;

  localparam logic [14:0] GRAY_CB   = 15'd1868;
  localparam logic [14:0] GRAY_CG   = 15'd9617;
  localparam logic [14:0] GRAY_CR   = 15'd4899;
  localparam logic [21:0] GRAY_RND  = 22'd8192;
  localparam logic [20:0] FRAC_RND  = 21'd2048;

  localparam logic [7:0] HUE_CENTER_RST = 8'd60;
  localparam logic [7:0] HUE_RANGE_RST  = 8'd40;
  localparam logic [7:0] SAT_MIN_RST    = 8'd50;
  localparam logic [7:0] VAL_MIN_RST    = 8'd50;

  localparam logic [8:0] BAND_LO_RST =
    9'((2 * HUE_CENTER_RST + HALF_TURN - HUE_RANGE_RST) % HALF_TURN);
  localparam logic [8:0] BAND_HI_RST =
    9'((2 * HUE_CENTER_RST + HALF_TURN + HUE_RANGE_RST) % HALF_TURN);

  typedef enum logic [7:0] {
    REG_HUE_CENTER = 8'd0,
    REG_HUE_RANGE  = 8'd1,
    REG_SAT_MIN    = 8'd2,
    REG_VAL_MIN    = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       kept_color;
  } res_t;

  typedef struct packed {
    logic [7:0] idx;
    logic [7:0] wdata;
  } cfg_t;

  // Reduce a half-hue sum below 1440 to 0..359.
  function automatic logic [8:0] mod_turn(input logic [10:0] x);
    logic [10:0] r;
    r = x;
    if (r >= 11'(3 * HALF_TURN)) begin
      r = r - 11'(3 * HALF_TURN);
    end else if (r >= 11'(2 * HALF_TURN)) begin
      r = r - 11'(2 * HALF_TURN);
    end else if (r >= 11'(HALF_TURN)) begin
      r = r - 11'(HALF_TURN);
    end
    return r[8:0];
  endfunction

endpackage

@@ sv/hrcs_if.sv @@
// Valid/ready channel interfaces for pixels, results and register writes.
// Payload types come from hrcs_pkg.
interface hrcs_pix_if;
  logic          valid;
  logic          ready;
  hrcs_pkg::pix_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hrcs_res_if;
  logic          valid;
  logic          ready;
  hrcs_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hrcs_cfg_if;
  logic          valid;
  logic          ready;
  hrcs_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/hue_range_color_splash.sv @@
// Hue-keyed color splash: BGR pixel to HSV, band test, keep color or luma gray.
// Depends on hrcs_pkg and the channel interfaces in hrcs_if.sv.
//
// Usage:
//   in_i   sink channel, one BGR pixel per beat (blue, green, red).
//   out_o  source channel, one result beat per pixel: channels unchanged and
//          kept_color high, or luma gray on all three and kept_color low.
//   cfg_i  register write channel, always ready; idx 0 hue_center,
//          1 hue_range, 2 sat_min, 3 val_min; other indexes are dropped.
//          Write only while no pixel is in flight.
// Throughput is one pixel per cycle while out_o is not stalled. Stages: max/min
// and hue numerator, reciprocal table lookup and luma sum, the two multipliers,
// then rounding, band test and output select. Each stage has its own valid bit
// and passes when the next one is empty or moving, so bubbles close up and a
// stalled receiver backs the pipe up without loss. Reset clears all valid bits
// and loads the register defaults (center 60, range 40, sat_min 50, val_min 50).
module hue_range_color_splash (
  input  logic             clk_i,
  input  logic             rst_ni,
  hrcs_pix_if.sink         in_i,
  hrcs_res_if.source       out_o,
  hrcs_cfg_if.sink         cfg_i
);

  logic [7:0] hue_center_q, hue_range_q, sat_min_q, val_min_q;
  logic [8:0] band_lo_q, band_hi_q;

  logic [19:0] sd_tab [hrcs_pkg::TAB_DEPTH];
  logic [16:0] hd_tab [hrcs_pkg::TAB_DEPTH];

  for (genvar i = 0; i < hrcs_pkg::TAB_DEPTH; i++) begin : g_tab
    localparam int unsigned SdDen = (i == 0) ? 1 : 2 * i;
    localparam int unsigned SdVal = (i == 0) ? 0 : (2 * hrcs_pkg::SAT_NUM + i) / SdDen;
    localparam int unsigned HdDen = (i == 0) ? 1 : 12 * i;
    localparam int unsigned HdVal = (i == 0) ? 0 : (2 * hrcs_pkg::HUE_NUM + 6 * i) / HdDen;
    assign sd_tab[i] = 20'(SdVal);
    assign hd_tab[i] = 17'(HdVal);
  end

  // Configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_center_q <= hrcs_pkg::HUE_CENTER_RST;
      hue_range_q  <= hrcs_pkg::HUE_RANGE_RST;
      sat_min_q    <= hrcs_pkg::SAT_MIN_RST;
      val_min_q    <= hrcs_pkg::VAL_MIN_RST;
      band_lo_q    <= hrcs_pkg::BAND_LO_RST;
      band_hi_q    <= hrcs_pkg::BAND_HI_RST;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.data.idx)
          hrcs_pkg::REG_HUE_CENTER: hue_center_q <= cfg_i.data.wdata;
          hrcs_pkg::REG_HUE_RANGE:  hue_range_q  <= cfg_i.data.wdata;
          hrcs_pkg::REG_SAT_MIN:    sat_min_q    <= cfg_i.data.wdata;
          hrcs_pkg::REG_VAL_MIN:    val_min_q    <= cfg_i.data.wdata;
          default: ;
        endcase
      end
      band_lo_q <= hrcs_pkg::mod_turn({2'b0, hue_center_q, 1'b0}
                   + 11'(hrcs_pkg::HALF_TURN) - {3'b0, hue_range_q});
      band_hi_q <= hrcs_pkg::mod_turn({2'b0, hue_center_q, 1'b0}
                   + 11'(hrcs_pkg::HALF_TURN) + {3'b0, hue_range_q});
    end
  end

  // Handshake chain
  logic va_q, vb_q, vc_q, vd_q;
  logic en_a, en_b, en_c, en_d;

  assign en_d = !vd_q || out_o.ready;
  assign en_c = !vc_q || en_d;
  assign en_b = !vb_q || en_c;
  assign en_a = !va_q || en_b;
  assign in_i.ready = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (en_a) va_q <= in_i.valid;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
      if (en_d) vd_q <= vc_q;
    end
  end

  // Stage A: max, min, hue numerator
  logic [7:0] in_b, in_g, in_r, max_d, min_d;
  logic signed [11:0] bs, gs, rs, ds, hraw_d;

  assign in_b = in_i.data.blue;
  assign in_g = in_i.data.green;
  assign in_r = in_i.data.red;

  always_comb begin
    max_d = in_r;
    if (in_g > max_d) max_d = in_g;
    if (in_b > max_d) max_d = in_b;
    min_d = in_r;
    if (in_g < min_d) min_d = in_g;
    if (in_b < min_d) min_d = in_b;
    bs = $signed({4'b0, in_b});
    gs = $signed({4'b0, in_g});
    rs = $signed({4'b0, in_r});
    ds = $signed({4'b0, 8'(max_d - min_d)});
    if (max_d == in_r) begin
      hraw_d = gs - bs;
    end else if (max_d == in_g) begin
      hraw_d = bs - rs + (ds <<< 1);
    end else begin
      hraw_d = rs - gs + (ds <<< 2);
    end
  end

  logic [7:0] b_a_q, g_a_q, r_a_q, v_a_q, d_a_q;
  logic signed [11:0] hraw_a_q;

  always_ff @(posedge clk_i) begin
    if (en_a && in_i.valid) begin
      b_a_q    <= in_b;
      g_a_q    <= in_g;
      r_a_q    <= in_r;
      v_a_q    <= max_d;
      d_a_q    <= 8'(max_d - min_d);
      hraw_a_q <= hraw_d;
    end
  end

  // Stage B: reciprocal lookup, luma sum
  logic [21:0] gray_sum;
  assign gray_sum = 22'(hrcs_pkg::GRAY_CB) * 22'(b_a_q)
                  + 22'(hrcs_pkg::GRAY_CG) * 22'(g_a_q)
                  + 22'(hrcs_pkg::GRAY_CR) * 22'(r_a_q) + hrcs_pkg::GRAY_RND;

  logic [7:0] b_b_q, g_b_q, r_b_q, v_b_q, d_b_q, gray_b_q;
  logic signed [11:0] hraw_b_q;
  logic [19:0] sd_b_q;
  logic [16:0] hd_b_q;

  always_ff @(posedge clk_i) begin
    if (en_b && va_q) begin
      b_b_q    <= b_a_q;
      g_b_q    <= g_a_q;
      r_b_q    <= r_a_q;
      v_b_q    <= v_a_q;
      d_b_q    <= d_a_q;
      hraw_b_q <= hraw_a_q;
      sd_b_q   <= sd_tab[v_a_q];
      hd_b_q   <= hd_tab[d_a_q];
      gray_b_q <= gray_sum[21:14];
    end
  end

  // Stage C: multipliers
  logic [7:0] b_c_q, g_c_q, r_c_q, v_c_q, gray_c_q;
  logic [20:0] sprod_c_q;
  logic signed [20:0] hprod_c_q;

  always_ff @(posedge clk_i) begin
    if (en_c && vb_q) begin
      b_c_q     <= b_b_q;
      g_c_q     <= g_b_q;
      r_c_q     <= r_b_q;
      v_c_q     <= v_b_q;
      gray_c_q  <= gray_b_q;
      sprod_c_q <= 21'(d_b_q) * 21'(sd_b_q);
      hprod_c_q <= 21'(hraw_b_q) * $signed(21'({1'b0, hd_b_q}));
    end
  end

  // Stage D: round, band test, select
  logic [20:0] s_sum;
  logic signed [20:0] h_sum;
  logic signed [8:0] h_fl;
  logic [7:0] hue;
  logic [8:0] h2, sat9;
  logic in_band, keep;

  always_comb begin
    s_sum = sprod_c_q + hrcs_pkg::FRAC_RND;
    sat9  = s_sum[20:12];
    h_sum = hprod_c_q + $signed(hrcs_pkg::FRAC_RND);
    h_fl  = $signed(h_sum[20:12]);
    if (h_fl < 0) begin
      hue = 8'(h_fl + 9'sd180);
    end else begin
      hue = 8'(h_fl);
    end
    h2 = {hue, 1'b0};
    if (band_lo_q <= band_hi_q) begin
      in_band = (h2 >= band_lo_q) && (h2 <= band_hi_q);
    end else begin
      in_band = (h2 >= band_lo_q) || (h2 <= band_hi_q);
    end
    keep = in_band && (sat9 >= {1'b0, sat_min_q}) && (v_c_q >= val_min_q);
  end

  hrcs_pkg::res_t res_q;

  always_ff @(posedge clk_i) begin
    if (en_d && vc_q) begin
      if (keep) begin
        res_q <= '{out_blue: b_c_q, out_green: g_c_q, out_red: r_c_q, kept_color: 1'b1};
      end else begin
        res_q <= '{out_blue: gray_c_q, out_green: gray_c_q, out_red: gray_c_q,
                   kept_color: 1'b0};
      end
    end
  end

  assign out_o.valid = vd_q;
  assign out_o.data  = res_q;

endmodule

@@ sv/hrcs_checker.sv @@
// Port-level checks for hue_range_color_splash, attached by bind.
// Depends on hrcs_pkg for the result type.
module hrcs_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input hrcs_pkg::res_t out_data_i,
  input logic           cfg_valid_i,
  input logic           cfg_ready_i
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("output valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result beat changed");

  a_gray_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.kept_color |->
      (out_data_i.out_blue == out_data_i.out_green)
      && (out_data_i.out_green == out_data_i.out_red))
    else $error("gray result with unequal channels");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("register write refused");

endmodule

bind hue_range_color_splash hrcs_checker u_hrcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready)
);

@@ verif/hrcs_checker.sv @@
// Watches the pixel, result and register write channels of the color splash block.
// Predicts each result from its own copy of the band registers and compares by field.
// Depends on hrcs_pkg and the channel interfaces in hrcs_if.sv.
module hrcs_tb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  hrcs_pix_if         pix_i,
  hrcs_res_if         res_i,
  hrcs_cfg_if         cfg_i,
  output int unsigned fail_cnt_o,
  output int unsigned outstanding_o
);

  logic [7:0] center_q;
  logic [7:0] range_q;
  logic [7:0] sat_min_q;
  logic [7:0] val_min_q;

  hrcs_pkg::res_t splash_q [$];

  function automatic hrcs_pkg::res_t color_splash(input hrcs_pkg::pix_t p,
                                                  input logic [7:0] ctr,
                                                  input logic [7:0] rng,
                                                  input logic [7:0] smin,
                                                  input logic [7:0] vmin);
    int unsigned b, g, r, vmax, vmin_ch, d, sat_rcp, sat, hue_rcp;
    int unsigned band_lo, band_hi, h2, gray;
    int hraw, hue;
    logic in_band;
    hrcs_pkg::res_t res;
    b = p.blue;
    g = p.green;
    r = p.red;
    vmax = r;
    vmin_ch = r;
    if (g > vmax) vmax = g;
    if (b > vmax) vmax = b;
    if (g < vmin_ch) vmin_ch = g;
    if (b < vmin_ch) vmin_ch = b;
    d = vmax - vmin_ch;

    sat_rcp = (vmax == 0) ? 0 : (2 * hrcs_pkg::SAT_NUM + vmax) / (2 * vmax);
    sat = (d * sat_rcp + 2048) >> 12;

    if (vmax == r) begin
      hraw = int'(g) - int'(b);
    end else if (vmax == g) begin
      hraw = int'(b) - int'(r) + 2 * int'(d);
    end else begin
      hraw = int'(r) - int'(g) + 4 * int'(d);
    end
    hue_rcp = (d == 0) ? 0 : (2 * hrcs_pkg::HUE_NUM + 6 * d) / (12 * d);
    hue = (hraw * int'(hue_rcp) + 2048) >>> 12;
    if (hue < 0) hue = hue + int'(hrcs_pkg::HUE_SPAN);

    // band edges in half-hue units
    band_lo = (2 * int'(ctr) + hrcs_pkg::HALF_TURN - int'(rng)) % hrcs_pkg::HALF_TURN;
    band_hi = (2 * int'(ctr) + hrcs_pkg::HALF_TURN + int'(rng)) % hrcs_pkg::HALF_TURN;
    h2 = 2 * hue;
    if (band_lo <= band_hi) begin
      in_band = (h2 >= band_lo) && (h2 <= band_hi);
    end else begin
      in_band = (h2 >= band_lo) || (h2 <= band_hi);
    end

    if (in_band && (sat >= smin) && (vmax >= vmin)) begin
      res.out_blue   = p.blue;
      res.out_green  = p.green;
      res.out_red    = p.red;
      res.kept_color = 1'b1;
    end else begin
      gray = (int'(hrcs_pkg::GRAY_CB) * b + int'(hrcs_pkg::GRAY_CG) * g
              + int'(hrcs_pkg::GRAY_CR) * r + 8192) >> 14;
      res.out_blue   = gray[7:0];
      res.out_green  = gray[7:0];
      res.out_red    = gray[7:0];
      res.kept_color = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hrcs_pkg::res_t want;
    int unsigned errs;
    if (!rst_ni) begin
      center_q      <= hrcs_pkg::HUE_CENTER_RST;
      range_q       <= hrcs_pkg::HUE_RANGE_RST;
      sat_min_q     <= hrcs_pkg::SAT_MIN_RST;
      val_min_q     <= hrcs_pkg::VAL_MIN_RST;
      splash_q.delete();
      fail_cnt_o    <= 0;
      outstanding_o <= 0;
    end else begin
      errs = 0;
      if (res_i.valid && res_i.ready) begin
        if (splash_q.size() == 0) begin
          $display("%0t result beat with nothing pending: got %h", $time, res_i.data);
          errs++;
        end else begin
          want = splash_q.pop_front();
          if (res_i.data.out_blue !== want.out_blue) begin
            $display("%0t out_blue expected %0d got %0d", $time, want.out_blue,
                     res_i.data.out_blue);
            errs++;
          end
          if (res_i.data.out_green !== want.out_green) begin
            $display("%0t out_green expected %0d got %0d", $time, want.out_green,
                     res_i.data.out_green);
            errs++;
          end
          if (res_i.data.out_red !== want.out_red) begin
            $display("%0t out_red expected %0d got %0d", $time, want.out_red,
                     res_i.data.out_red);
            errs++;
          end
          if (res_i.data.kept_color !== want.kept_color) begin
            $display("%0t kept_color expected %0d got %0d", $time, want.kept_color,
                     res_i.data.kept_color);
            errs++;
          end
        end
      end
      if (pix_i.valid && pix_i.ready) begin
        splash_q.push_back(color_splash(pix_i.data, center_q, range_q, sat_min_q,
                                        val_min_q));
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.data.idx)
          hrcs_pkg::REG_HUE_CENTER: center_q  <= cfg_i.data.wdata;
          hrcs_pkg::REG_HUE_RANGE:  range_q   <= cfg_i.data.wdata;
          hrcs_pkg::REG_SAT_MIN:    sat_min_q <= cfg_i.data.wdata;
          hrcs_pkg::REG_VAL_MIN:    val_min_q <= cfg_i.data.wdata;
          default: ;
        endcase
      end
      fail_cnt_o    <= fail_cnt_o + errs;
      outstanding_o <= splash_q.size();
    end
  end

endmodule

@@ verif/tb_hue_range_color_splash.sv @@
// Top of the color splash testbench: clock, reset, pixel and register stimulus, verdict.
// Instantiates hue_range_color_splash beside hrcs_tb_checker; depends on hrcs_pkg and hrcs_if.sv.
module tb_hue_range_color_splash;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned PHASE_PIXELS = 83;
  localparam int unsigned NUM_BANDS    = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic rdy_q = 1'b0;
  int unsigned rdy_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned fail_cnt;
  int unsigned outstanding;

  hrcs_pix_if pix_ch ();
  hrcs_res_if res_ch ();
  hrcs_cfg_if cfg_ch ();

  always #6 clk_i = ~clk_i;

  assign res_ch.ready = rdy_q;

  hue_range_color_splash u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pix_ch),
    .out_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  hrcs_tb_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_i         (pix_ch),
    .res_i         (res_ch),
    .cfg_i         (cfg_ch),
    .fail_cnt_o    (fail_cnt),
    .outstanding_o (outstanding)
  );

  always @(posedge clk_i) begin
    if (rdy_left != 0) begin
      rdy_left <= rdy_left - 1;
    end else if (rdy_q) begin
      rdy_q    <= 1'b0;
      rdy_left <= $urandom_range(0, 11);
    end else if ($urandom_range(0, 3) == 0) begin
      rdy_q    <= 1'b1;
      rdy_left <= $urandom_range(40, 90);
    end else begin
      rdy_q    <= 1'b1;
      rdy_left <= $urandom_range(0, 15);
    end
  end

  always @(posedge clk_i) begin
    if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(input hrcs_pkg::pix_t p);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.data  <= p;
    do @(posedge clk_i); while (!pix_ch.ready);
    burst_left--;
    if (burst_left == 0) pix_ch.valid <= 1'b0;
  endtask

  // drop valid and wait out every pending result
  task automatic drain_pixels();
    if (burst_left != 0) begin
      pix_ch.valid <= 1'b0;
      burst_left = 0;
    end
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= hrcs_pkg::cfg_t'({idx, val});
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  task automatic program_band(input logic [7:0] ctr, input logic [7:0] rng,
                              input logic [7:0] smin, input logic [7:0] vmin);
    write_reg(hrcs_pkg::REG_HUE_CENTER, ctr);
    write_reg(hrcs_pkg::REG_HUE_RANGE, rng);
    write_reg(hrcs_pkg::REG_SAT_MIN, smin);
    write_reg(hrcs_pkg::REG_VAL_MIN, vmin);
    // unmapped index, must leave the band alone
    write_reg(8'($urandom_range(4, 255)), 8'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic hrcs_pkg::pix_t rand_pixel();
    logic [7:0] top, bot, mid;
    logic [7:0] ch [3];
    int unsigned k;
    int i;
    hrcs_pkg::pix_t p;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: p = 24'($urandom);
      4, 5, 6: begin
        top = 8'($urandom_range(40, 255));
        bot = 8'($urandom_range(0, top / 4));
        mid = 8'($urandom_range(bot, top));
        ch  = '{top, bot, mid};
        k = $urandom_range(0, 2);
        p.blue  = ch[k];
        p.green = ch[(k + 1) % 3];
        p.red   = ch[(k + 2) % 3];
        if ($urandom_range(0, 1) == 1) {p.green, p.red} = {p.red, p.green};
      end
      7: begin
        top = 8'($urandom);
        p = {top, top, top};
      end
      8: begin
        top = 8'($urandom_range(3, 255));
        p.blue  = top - 8'($urandom_range(0, 3));
        p.green = top - 8'($urandom_range(0, 3));
        p.red   = top - 8'($urandom_range(0, 3));
      end
      default: begin
        for (i = 0; i < 3; i++) begin
          case ($urandom_range(0, 4))
            0: ch[i] = 8'd0;
            1: ch[i] = 8'd1;
            2: ch[i] = 8'd254;
            3: ch[i] = 8'd255;
            default: ch[i] = 8'($urandom);
          endcase
        end
        p = {ch[0], ch[1], ch[2]};
      end
    endcase
    return p;
  endfunction

  initial begin
    hrcs_pkg::pix_t corner [$];
    logic [7:0] bands [6][4];
    int unsigned ph;
    int unsigned n;
    pix_ch.valid = 1'b0;
    pix_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    // blue, green, red
    corner = '{24'h000000, 24'hffffff, 24'h808080, 24'h010101, 24'h0000ff, 24'h00ff00,
               24'hff0000, 24'h00ffff, 24'hffff00, 24'hff00ff, 24'h0a00ff, 24'h0080ff,
               24'h00c800, 24'h002800, 24'hc8dcc8, 24'h00c8c8, 24'hc8c800, 24'h1e3cff,
               24'hfffffe, 24'h000100, 24'h7f8081};
    bands = '{'{8'd0,   8'd40,  8'd50,  8'd50},
              '{8'd179, 8'd180, 8'd0,   8'd0},
              '{8'd90,  8'd0,   8'd0,   8'd0},
              '{8'd255, 8'd255, 8'd255, 8'd255},
              '{8'd120, 8'd61,  8'd128, 8'd200},
              '{8'd30,  8'd7,   8'd10,  8'd10}};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (corner[i]) send_pixel(corner[i]);
    for (n = 0; n < PHASE_PIXELS; n++) send_pixel(rand_pixel());
    drain_pixels();

    for (ph = 0; ph < NUM_BANDS; ph++) begin
      if (ph < 6) begin
        program_band(bands[ph][0], bands[ph][1], bands[ph][2], bands[ph][3]);
      end else begin
        program_band(8'($urandom_range(0, 179)), 8'($urandom_range(0, 180)),
                     8'($urandom_range(0, 160)), 8'($urandom_range(0, 160)));
      end
      if (ph == 2) begin
        foreach (corner[i]) send_pixel(corner[i]);
      end
      for (n = 0; n < PHASE_PIXELS; n++) send_pixel(rand_pixel());
      drain_pixels();
    end

    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
